FILE: rtl/core/clj_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clj_pkg
// types and constants shared by the capped lennard-jones obstacle force block
// ----------------------------------------------------------------------------
package clj_pkg;

  localparam int MAX_RODS = 1024;
  localparam int ROD_W    = $clog2(MAX_RODS);

  typedef struct packed {
    logic signed [31:0] seg_x;
    logic signed [31:0] seg_y;
    logic signed [31:0] mass_x;
    logic signed [31:0] mass_y;
    logic [ROD_W-1:0]   rod_id;
    logic               last_segment;
  } clj_req_t;

  typedef struct packed {
    logic [ROD_W-1:0]   rod_index;
    logic signed [47:0] total_fx;
    logic signed [47:0] total_fy;
    logic signed [47:0] total_torque;
  } clj_rsp_t;

  localparam logic [2:0] REG_CX    = 3'd0;
  localparam logic [2:0] REG_CY    = 3'd1;
  localparam logic [2:0] REG_CUT   = 3'd2;
  localparam logic [2:0] REG_SIGMA = 3'd3;
  localparam logic [2:0] REG_ALPHA = 3'd4;
  localparam logic [2:0] REG_STR   = 3'd5;

  localparam logic [61:0] CAP   = {62{1'b1}};
  localparam logic [46:0] MAX47 = {47{1'b1}};

  // divider control between sequencer and divider
  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [63:0] den;
  } clj_div_req_t;

endpackage
`default_nettype wire

FILE: rtl/core/clj_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clj_div
// radix-2 restoring divider, 64-bit unsigned, one quotient bit per cycle
// ----------------------------------------------------------------------------
module clj_div
  import clj_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire clj_div_req_t req,
  output logic              done,
  output logic [63:0]       quo
);

  logic [63:0] rem;
  logic [63:0] num;
  logic [63:0] den;
  logic [6:0]  cnt;
  logic        busy;
  logic [64:0] trial;

  assign trial = {rem, num[63]} - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 7'd64;
        rem  <= '0;
        num  <= req.num;
        den  <= req.den;
      end else if (busy) begin
        num <= {num[62:0], 1'b0};
        if (!trial[64]) begin
          rem <= trial[63:0];
          quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= {rem[62:0], num[63]};
          quo <= {quo[62:0], 1'b0};
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/clj_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clj_mul
// saturating multiply a*b>>16, a full product of 2^64 or more gives 2^62-1,
// built from 32x32 partials, one partial product per cycle
// ----------------------------------------------------------------------------
module clj_mul (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [61:0] a,
  input  wire logic [61:0] b,
  output logic             done,
  output logic [61:0]      p
);

  logic [61:0]  ra;
  logic [61:0]  rb;
  logic [1:0]   step;
  logic         busy;
  logic [127:0] acc;
  logic [31:0]  pa;
  logic [31:0]  pb;
  logic [63:0]  prod;
  logic [127:0] prod_sh;

  always_comb begin
    pa = step[1] ? {2'b0, ra[61:32]} : ra[31:0];
    pb = step[0] ? {2'b0, rb[61:32]} : rb[31:0];
    prod = {32'd0, pa} * {32'd0, pb};
    prod_sh = {64'd0, prod} << ({5'd0, step[1]} * 7'd32 + {5'd0, step[0]} * 7'd32);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= 2'd0;
        ra   <= a;
        rb   <= b;
        acc  <= '0;
      end else if (busy) begin
        acc  <= acc + prod_sh;
        step <= step + 2'd1;
        if (step == 2'd3) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign p = (acc[127:64] != '0) ? {62{1'b1}} : {14'd0, acc[63:16]};

endmodule
`default_nettype wire

FILE: rtl/core/capped_lj_obstacle_force_torque.sv
`default_nettype none
// ----------------------------------------------------------------------------
// capped_lj_obstacle_force_torque
// capped lennard-jones obstacle force and torque accumulator for rod segments
// ----------------------------------------------------------------------------
// One request is one rod segment. A sequencer drives one 64-bit restoring
// divider (used twice: sigma/d and 1/d) and one saturating multiplier (four
// 32x32 partials per product, used up to nine times); a segment outside the
// cut-off uses neither. A new request is taken only in the idle state, after
// the previous segment is through. Sums saturate to 48-bit Q32.16; on the
// last segment they are offered on the response channel from an output
// register and cleared. Further segments are taken while a response waits; a
// later last segment stalls until it is gone.
module capped_lj_obstacle_force_torque
  import clj_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire clj_req_t    in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output clj_rsp_t         out_data,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam logic [4:0] S_IDLE = 5'd0,  S_DIST = 5'd1,  S_R2 = 5'd2,  S_DS = 5'd3,
                         S_WS = 5'd4,  S_M1 = 5'd5,  S_M2 = 5'd6,  S_T  = 5'd7,
                         S_M3 = 5'd8,  S_M4 = 5'd9,  S_DI = 5'd10, S_WI = 5'd11,
                         S_M5 = 5'd12, S_MX = 5'd13, S_MY = 5'd14, S_TQ1 = 5'd15,
                         S_TQ2 = 5'd16, S_ACC = 5'd17, S_OUT = 5'd18, S_WM = 5'd19;

  logic signed [31:0] cx, cy;
  logic [31:0] cut, sig, alp, strn;
  logic [4:0]  state, ret;
  clj_req_t    req;
  logic signed [32:0] dx, dy, ax, ay;
  logic [32:0] adx, ady;
  logic [61:0] dd, s, s3, t, m, f;
  logic        tneg;
  logic signed [47:0] fx, fy, t1;
  logic signed [47:0] acc_fx, acc_fy, acc_tq;

  clj_div_req_t dreq;
  logic        ddone;
  logic [63:0] dquo;
  logic        mstart, mdone;
  logic [61:0] ma, mb, mp;

  clj_div u_div (.clk, .rst, .req(dreq), .done(ddone), .quo(dquo));
  clj_mul u_mul (.clk, .rst, .start(mstart), .a(ma), .b(mb), .done(mdone), .p(mp));

  function automatic logic signed [47:0] sgn47(input logic [61:0] mg, input logic ng);
    logic [46:0] v;
    v = (mg > {15'd0, MAX47}) ? MAX47 : mg[46:0];
    return ng ? -$signed({1'b0, v}) : $signed({1'b0, v});
  endfunction

  function automatic logic signed [47:0] sat_add(input logic signed [47:0] a,
                                                  input logic signed [47:0] b);
    logic signed [48:0] sm;
    sm = {a[47], a} + {b[47], b};
    if (sm[48] != sm[47]) return sm[48] ? {1'b1, 47'd0} : {1'b0, MAX47};
    return sm[47:0];
  endfunction

  // squares only matter below the far limit, so 24 bits per side suffice
  logic [47:0] sqx, sqy;
  logic [63:0] r2full;
  logic [61:0] two_s3;
  assign sqx = adx[23:0] * adx[23:0];
  assign sqy = ady[23:0] * ady[23:0];
  assign r2full = {16'd0, sqx} + {16'd0, sqy};
  assign two_s3 = {s3[60:0], 1'b0};

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      cx <= '0; cy <= '0;
      cut <= 32'd65536; sig <= 32'd65536; alp <= 32'd65536; strn <= 32'd65536;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CX:    cx <= cfg_data;
        REG_CY:    cy <= cfg_data;
        REG_CUT:   cut <= cfg_data;
        REG_SIGMA: sig <= cfg_data;
        REG_ALPHA: alp <= cfg_data;
        REG_STR:   strn <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret <= S_IDLE;
      out_valid <= 1'b0;
      acc_fx <= '0; acc_fy <= '0; acc_tq <= '0;
      dreq.start <= 1'b0;
      mstart <= 1'b0;
    end else begin
      dreq.start <= 1'b0;
      mstart <= 1'b0;
      if (out_valid && out_ready && !(state == S_ACC && req.last_segment))
        out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (in_valid && in_ready) begin
          req <= in_data;
          state <= S_DIST;
        end
        S_DIST: begin
          dx <= {req.seg_x[31], req.seg_x} - {cx[31], cx};
          dy <= {req.seg_y[31], req.seg_y} - {cy[31], cy};
          ax <= {req.seg_x[31], req.seg_x} - {req.mass_x[31], req.mass_x};
          ay <= {req.seg_y[31], req.seg_y} - {req.mass_y[31], req.mass_y};
          fx <= '0; fy <= '0; t1 <= '0;
          state <= S_R2;
        end
        S_R2: begin
          adx <= dx[32] ? -dx : dx;
          ady <= dy[32] ? -dy : dy;
          state <= S_DS;
        end
        S_DS: begin
          if (adx >= 33'd16777216 || ady >= 33'd16777216 ||
              r2full > {16'd0, cut, 16'd0} ||
              ({30'd0, alp} + {14'd0, r2full[63:16]}) == 62'd0) begin
            state <= S_ACC;
          end else begin
            dd <= {30'd0, alp} + {14'd0, r2full[63:16]};
            dreq.start <= 1'b1;
            dreq.num <= {16'd0, sig, 16'd0};
            dreq.den <= {2'd0, {30'd0, alp} + {14'd0, r2full[63:16]}};
            state <= S_WS;
          end
        end
        S_WS: if (ddone) begin
          s <= (dquo[63:62] != 2'd0) ? CAP : dquo[61:0];
          ma <= (dquo[63:62] != 2'd0) ? CAP : dquo[61:0];
          mb <= (dquo[63:62] != 2'd0) ? CAP : dquo[61:0];
          mstart <= 1'b1;
          ret <= S_M1;
          state <= S_WM;
        end
        S_M1: begin
          ma <= mp; mb <= s; mstart <= 1'b1; ret <= S_M2; state <= S_WM;
        end
        S_M2: begin
          s3 <= mp; state <= S_T;
        end
        S_T: begin
          if (s3[61] || two_s3 >= 62'd65536) begin
            t <= s3[61] ? CAP : two_s3 - 62'd65536; tneg <= 1'b0;
          end else begin
            t <= 62'd65536 - two_s3; tneg <= 1'b1;
          end
          ma <= {30'd0, strn}; mb <= s3; mstart <= 1'b1; ret <= S_M3; state <= S_WM;
        end
        S_M3: begin
          ma <= mp; mb <= t; mstart <= 1'b1; ret <= S_M4; state <= S_WM;
        end
        S_M4: begin
          m <= mp;
          dreq.start <= 1'b1;
          dreq.num <= 64'd1 << 40;
          dreq.den <= {2'd0, dd};
          state <= S_DI;
        end
        S_DI: state <= S_WI;
        S_WI: if (ddone) begin
          ma <= m; mb <= dquo[61:0]; mstart <= 1'b1; ret <= S_M5; state <= S_WM;
        end
        S_M5: begin
          f <= mp;
          ma <= {29'd0, adx}; mb <= mp; mstart <= 1'b1; ret <= S_MX; state <= S_WM;
        end
        S_MX: begin
          fx <= sgn47(mp, dx[32] != tneg);
          ma <= {29'd0, ady}; mb <= f; mstart <= 1'b1; ret <= S_MY; state <= S_WM;
        end
        S_MY: begin
          fy <= sgn47(mp, dy[32] != tneg);
          if (mp == '0 && fx == '0) begin
            state <= S_ACC;
          end else begin
            ma <= {29'd0, ax[32] ? -ax : ax};
            mb <= (mp > {15'd0, MAX47}) ? {15'd0, MAX47} : {15'd0, mp[46:0]};
            mstart <= 1'b1; ret <= S_TQ1; state <= S_WM;
          end
        end
        S_TQ1: begin
          t1 <= sgn47(mp, ax[32] != fy[47]);
          ma <= {29'd0, ay[32] ? -ay : ay};
          mb <= {15'd0, fx[47] ? -fx[46:0] : fx[46:0]};
          mstart <= 1'b1; ret <= S_TQ2; state <= S_WM;
        end
        S_TQ2: begin
          t1 <= sat_add(t1, -sgn47(mp, ay[32] != fx[47]));
          state <= S_ACC;
        end
        S_ACC: begin
          if (!req.last_segment) begin
            acc_fx <= sat_add(acc_fx, fx);
            acc_fy <= sat_add(acc_fy, fy);
            acc_tq <= sat_add(acc_tq, t1);
            state <= S_IDLE;
          end else if (!out_valid || out_ready) begin
            out_data.rod_index <= req.rod_id;
            out_data.total_fx <= sat_add(acc_fx, fx);
            out_data.total_fy <= sat_add(acc_fy, fy);
            out_data.total_torque <= sat_add(acc_tq, t1);
            out_valid <= 1'b1;
            acc_fx <= '0; acc_fy <= '0; acc_tq <= '0;
            state <= S_IDLE;
          end
        end
        S_WM: if (mdone) state <= ret;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: sim/capped_lj_obstacle_force_torque_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// capped_lj_obstacle_force_torque_tb
// checks rod force and torque sums against a bit-exact fixed-point predictor
// ----------------------------------------------------------------------------
// Directed segments cover field extremes, the cut-off edge, far offsets, a
// zero denominator and mixed rods. Random rods follow under several register
// settings. Both channels idle at random. Each response is compared field by
// field with the oldest predicted rod total.
// ----------------------------------------------------------------------------
module capped_lj_obstacle_force_torque_tb;
  import clj_pkg::*;

  localparam logic [63:0] CAP64  = 64'h3FFF_FFFF_FFFF_FFFF;
  localparam longint      HI47   = 64'sh7FFF_FFFF_FFFF;
  localparam longint      LO47   = -64'sh8000_0000_0000;
  localparam longint      FAR    = 64'sd16777216;
  localparam int          LIMIT  = 6000000;

  logic     clk = 0;
  logic     rst = 1;
  logic     in_valid = 0;
  logic     in_ready;
  clj_req_t in_data = '0;
  logic     out_valid;
  logic     out_ready = 0;
  clj_rsp_t out_data;
  logic     cfg_we = 0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  capped_lj_obstacle_force_torque dut (.*);

  always #4 clk = ~clk;

  // predictor state
  logic [31:0] cx, cy, cut_sq, sig_sq, alp_sq, stren;
  longint      sum_fx, sum_fy, sum_tq;
  clj_rsp_t    rod_totals[$];
  int  errors = 0, cycles = 0, sent = 0, reports = 0;
  bit  calm = 0;

  function automatic logic [63:0] mul_cap(logic [63:0] a, logic [63:0] b, int sh);
    logic [127:0] p;
    p = a * b;
    if (p[127:64] != 0) return CAP64;
    p = p[63:0] >> sh;
    return (p > CAP64) ? CAP64 : p[63:0];
  endfunction

  function automatic longint sgn47(logic [63:0] m, bit neg);
    longint v;
    v = (m > 64'h7FFF_FFFF_FFFF) ? HI47 : longint'(m);
    return neg ? -v : v;
  endfunction

  function automatic longint clip48(longint v);
    if (v > HI47) return HI47;
    if (v < LO47) return LO47;
    return v;
  endfunction

  function automatic logic [63:0] absv(longint v);
    return v < 0 ? -v : v;
  endfunction

  task automatic predict_segment(clj_req_t r);
    longint dx, dy, ax, ay, fx, fy, tq, t1, t2;
    logic [63:0] adx, ady, r2, d, s, s3, t, m, inv, f;
    bit tneg;
    clj_rsp_t e;
    dx = longint'(r.seg_x) - longint'($signed(cx));
    dy = longint'(r.seg_y) - longint'($signed(cy));
    adx = absv(dx); ady = absv(dy);
    fx = 0; fy = 0; tq = 0;
    if (adx < FAR && ady < FAR) begin
      r2 = adx * adx + ady * ady;
      if (r2 <= ({32'b0, cut_sq} << 16)) begin
        d = {32'b0, alp_sq} + (r2 >> 16);
        if (d != 0) begin
          s = ({32'b0, sig_sq} << 16) / d;
          if (s > CAP64) s = CAP64;
          s3 = mul_cap(mul_cap(s, s, 16), s, 16);
          if (2 * s3 >= 64'd65536) begin
            t = 2 * s3 - 64'd65536; tneg = 0;
          end else begin
            t = 64'd65536 - 2 * s3; tneg = 1;
          end
          m = mul_cap(mul_cap({32'b0, stren}, s3, 16), t, 16);
          inv = (64'd1 << 40) / d;
          f = mul_cap(m, inv, 16);
          fx = sgn47(mul_cap(adx, f, 16), (dx < 0) != tneg);
          fy = sgn47(mul_cap(ady, f, 16), (dy < 0) != tneg);
        end
      end
    end
    if (fx != 0 || fy != 0) begin
      ax = longint'(r.seg_x) - longint'(r.mass_x);
      ay = longint'(r.seg_y) - longint'(r.mass_y);
      t1 = sgn47(mul_cap(absv(ax), absv(fy), 16), (ax < 0) != (fy < 0));
      t2 = sgn47(mul_cap(absv(ay), absv(fx), 16), (ay < 0) != (fx < 0));
      tq = clip48(t1 - t2);
    end
    sum_fx = clip48(sum_fx + fx);
    sum_fy = clip48(sum_fy + fy);
    sum_tq = clip48(sum_tq + tq);
    if (r.last_segment) begin
      e.rod_index = r.rod_id;
      e.total_fx = sum_fx[47:0];
      e.total_fy = sum_fy[47:0];
      e.total_torque = sum_tq[47:0];
      rod_totals.push_back(e);
      sum_fx = 0; sum_fy = 0; sum_tq = 0;
    end
  endtask

  task automatic send_segment(clj_req_t r);
    while (!calm && $urandom_range(99) < 34) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    in_data <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_segment(r);
    sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (rod_totals.size() != 0) @(negedge clk);
    repeat (400) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] v);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
    @(negedge clk);
    cfg_we <= 0;
    @(negedge clk);
    case (idx)
      REG_CX:    cx = v;
      REG_CY:    cy = v;
      REG_CUT:   cut_sq = v;
      REG_SIGMA: sig_sq = v;
      REG_ALPHA: alp_sq = v;
      REG_STR:   stren = v;
      default: ;
    endcase
  endtask

  function automatic clj_req_t seg(int x, int y, int mx, int my, int id, bit last);
    clj_req_t r;
    r.seg_x = x; r.seg_y = y; r.mass_x = mx; r.mass_y = my;
    r.rod_id = ROD_W'(id); r.last_segment = last;
    return r;
  endfunction

  // random offset near the obstacle, mostly within a few units
  function automatic int near(logic [31:0] c);
    case ($urandom_range(9))
      0: return $urandom;
      1: return c + $signed($urandom_range(32'h0400_0000)) - 32'sh0200_0000;
      default: return c + $signed($urandom_range(32'h0006_0000)) - 32'sh0003_0000;
    endcase
  endfunction

  task automatic test_directed();
    send_segment(seg(32'sh0000_8000, 0, 0, 0, 1, 1));
    send_segment(seg(0, 32'sh0000_4000, 32'sh0001_0000, 0, 2, 1));
    send_segment(seg(0, 0, 0, 0, 3, 1));
    send_segment(seg(32'sh0001_0000, 0, 0, 32'sh0001_0000, 4, 1));
    send_segment(seg(32'sh0001_0001, 0, 0, 0, 5, 1));
    send_segment(seg(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 1023, 1));
    send_segment(seg(32'sh00FF_FFFF, 0, 0, 0, 6, 1));
    send_segment(seg(32'shFFFF_C000, 32'shFFFF_C000, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0));
    send_segment(seg(32'sh0000_2000, 32'shFFFF_E000, 32'sh8000_0000, 32'sh7FFF_FFFF, 9, 0));
    send_segment(seg(32'shFFFF_F000, 32'sh0000_1000, 0, 0, 10, 1));
    send_segment(seg(32'shFFFF_FFFF, 32'shFFFF_FFFF, 32'shFFFF_FFFF, 32'shFFFF_FFFF, 1023, 1));
    drain();
    write_reg(REG_ALPHA, 0);
    send_segment(seg(0, 0, 0, 0, 11, 1));
    send_segment(seg(32'sh0000_0100, 0, 32'sh8000_0000, 0, 12, 1));
    drain();
    write_reg(REG_STR, 32'hFFFF_FFFF);
    write_reg(REG_SIGMA, 32'hFFFF_FFFF);
    write_reg(REG_CUT, 32'hFFFF_FFFF);
    for (int i = 0; i < 6; i++)
      send_segment(seg(32'sh0000_0010 << i, 32'shFFFF_0000 >> i, 32'sh7FFF_0000,
                       32'sh8001_0000, 13 + i, i[0]));
    send_segment(seg(32'sh00FF_0000, 32'sh00FF_0000, 0, 0, 20, 1));
    drain();
  endtask

  task automatic test_random_rods(int count);
    int n, k;
    n = 0;
    while (n < count) begin
      k = $urandom_range(1, 6);
      for (int j = 0; j < k && n < count; j++, n++)
        send_segment(seg(near(cx), near(cy), $urandom, $urandom, $urandom_range(1023),
                         (j == k - 1) || ($urandom_range(19) == 0)));
    end
    drain();
  endtask

  task automatic test_settings();
    logic [31:0] v;
    for (int p = 0; p < 6; p++) begin
      write_reg(REG_CX, (p == 1) ? 32'h8000_0000 : (p == 2) ? 32'h7FFF_FFFF : $urandom);
      write_reg(REG_CY, (p == 1) ? 32'h7FFF_FFFF : (p == 2) ? 32'h8000_0000 : $urandom);
      write_reg(REG_CUT, (p == 3) ? 0 : (p == 4) ? 32'hFFFF_FFFF : $urandom_range(32'h0010_0000));
      write_reg(REG_SIGMA, (p == 3) ? 0 : (p == 4) ? 32'hFFFF_FFFF : $urandom_range(32'h0004_0000));
      v = (p == 5) ? 0 : $urandom_range(1, 32'h0002_0000);
      write_reg(REG_ALPHA, v);
      write_reg(REG_STR, (p == 3) ? 0 : (p == 4) ? 32'hFFFF_FFFF : $urandom);
      calm = (p == 2);
      test_random_rods(190);
      calm = 0;
    end
  endtask

  // response side
  always @(negedge clk) begin
    if (!rst) out_ready <= calm || ($urandom_range(99) >= 34);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && out_valid && out_ready) begin
      clj_rsp_t e;
      reports <= reports + 1;
      if (rod_totals.size() == 0) begin
        $display("%0t unexpected response %h", $time, out_data);
        errors++;
      end else begin
        e = rod_totals.pop_front();
        if (e.rod_index !== out_data.rod_index) begin
          $display("%0t rod_index exp %0d got %0d", $time, e.rod_index, out_data.rod_index);
          errors++;
        end
        if (e.total_fx !== out_data.total_fx) begin
          $display("%0t total_fx exp %h got %h", $time, e.total_fx, out_data.total_fx);
          errors++;
        end
        if (e.total_fy !== out_data.total_fy) begin
          $display("%0t total_fy exp %h got %h", $time, e.total_fy, out_data.total_fy);
          errors++;
        end
        if (e.total_torque !== out_data.total_torque) begin
          $display("%0t total_torque exp %h got %h", $time, e.total_torque,
                   out_data.total_torque);
          errors++;
        end
      end
    end
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    cx = 0; cy = 0; cut_sq = 32'h1_0000; sig_sq = 32'h1_0000;
    alp_sq = 32'h1_0000; stren = 32'h1_0000;
    sum_fx = 0; sum_fy = 0; sum_tq = 0;
    repeat (8) @(negedge clk);
    rst <= 0;
    @(negedge clk);
    test_directed();
    test_settings();
    $display("sent %0d segments, checked %0d rod totals over several register settings",
             sent, reports);
    if (errors == 0 && rod_totals.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end
endmodule
